>>> hw/rtl/at_response_line_classifier_defines.svh
// ----------------------------------------------------------------------------
// AT response line classifier assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define AT_RLC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AT_RLC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/at_rlc_pkg.sv
// ----------------------------------------------------------------------------
// AT response line classifier package
// Line class codes, character codes and keyword tables.
// ----------------------------------------------------------------------------
`default_nettype none

package at_rlc_pkg;

	typedef logic [3:0] line_class_t;

	localparam line_class_t CLASS_OK           = 4'd0;
	localparam line_class_t CLASS_ERROR        = 4'd1;
	localparam line_class_t CLASS_READY        = 4'd2;
	localparam line_class_t CLASS_CONNECTED    = 4'd3;
	localparam line_class_t CLASS_DISCONNECTED = 4'd4;
	localparam line_class_t CLASS_ADVERTISING  = 4'd5;
	localparam line_class_t CLASS_OTHER_PLUS   = 4'd6;
	localparam line_class_t CLASS_APP_CMD      = 4'd7;
	localparam line_class_t CLASS_OVERFLOW     = 4'd8;

	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_RESET = 1'b1;

	localparam logic [7:0] CHAR_CR   = 8'd13;
	localparam logic [7:0] CHAR_LF   = 8'd10;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;

	localparam int NUM_KW     = 6;
	localparam int MAX_KW_LEN = 13;

	typedef logic [NUM_KW-1:0] kw_mask_t;

	localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd3, 4'd4, 4'd6, 4'd10, 4'd13, 4'd12};

	// keyword text, left justified, zero padded to MAX_KW_LEN characters
	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
		logic [8*MAX_KW_LEN-1:0] row;
		logic [7:0]              ch;
		case (k)
			3'd0: row = {"+OK", {10{8'h00}}};
			3'd1: row = {"+ERR", {9{8'h00}}};
			3'd2: row = {"+READY", {7{8'h00}}};
			3'd3: row = {"+CONNECTED", {3{8'h00}}};
			3'd4: row = "+DISCONNECTED";
			3'd5: row = {"+ADVERTISING", 8'h00};
			default: row = '0;
		endcase
		if (pos < 4'(MAX_KW_LEN)) begin
			ch = row[8*MAX_KW_LEN-1 - 8*pos -: 8];
		end else begin
			ch = 8'h00;
		end
		return ch;
	endfunction

	typedef struct packed {
		logic        valid;
		line_class_t line_class;
	} rlc_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/at_rlc_parser.sv
// ----------------------------------------------------------------------------
// AT response line parser
// Line length, leading plus flag and keyword match flags; one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module at_rlc_parser #(
	parameter int LINE_BUF_SIZE = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic               action,
	input  wire logic [7:0]         byte_value,
	output at_rlc_pkg::rlc_res_t    res
);
	import at_rlc_pkg::*;

	localparam int              LEN_W    = $clog2(LINE_BUF_SIZE);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BUF_SIZE - 1);

	logic [LEN_W-1:0] len_q;
	logic             plus_q;
	kw_mask_t         alive_q;

	logic        is_eol;
	logic        is_full;
	kw_mask_t    kill;
	line_class_t cls;

	assign is_eol  = (byte_value == CHAR_CR) || (byte_value == CHAR_LF);
	assign is_full = (len_q >= LEN_LAST);

	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			kill[k] = (LEN_W'(KW_LEN[k]) > len_q) &&
				(byte_value != kw_char(3'(k), len_q[3:0]));
		end
	end

	// first full keyword match wins
	always_comb begin
		cls = plus_q ? CLASS_OTHER_PLUS : CLASS_APP_CMD;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (alive_q[k] && (len_q >= LEN_W'(KW_LEN[k]))) begin
				cls = line_class_t'(k);
			end
		end
	end

	always_comb begin
		res = '0;
		if (step && (action == ACT_BYTE)) begin
			if (is_eol) begin
				res.valid      = (len_q != '0);
				res.line_class = cls;
			end else if (is_full) begin
				res.valid      = 1'b1;
				res.line_class = CLASS_OVERFLOW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			plus_q  <= 1'b0;
			alive_q <= '1;
		end else if (step) begin
			if ((action == ACT_RESET) || is_eol || is_full) begin
				len_q   <= '0;
				plus_q  <= 1'b0;
				alive_q <= '1;
			end else begin
				if (len_q == '0) begin
					plus_q <= (byte_value == CHAR_PLUS);
				end
				alive_q <= alive_q & ~kill;
				len_q   <= len_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/at_response_line_classifier.sv
// Path to the output: input register stage, parser, result register.
// Throughput: one input transfer per cycle while the output is taken.
// The single parser pass (length, keyword flags, class select) bounds the clock.
// Reset (arst_n low) empties both registers and clears the line state.
// ----------------------------------------------------------------------------
// AT response line classifier
// Classifies CR/LF terminated UART lines by their AT response prefix.
// ----------------------------------------------------------------------------
`default_nettype none
`include "at_response_line_classifier_defines.svh"

module at_response_line_classifier #(
	parameter int LINE_BUF_SIZE = 128
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     action,
	input  wire logic [7:0]               byte_value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output at_rlc_pkg::line_class_t       line_class
);
	import at_rlc_pkg::*;

	// input register stage
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	// result register
	logic        out_valid_q;
	line_class_t class_q;

	logic     adv;
	logic     step;
	rlc_res_t res;

	// The staged byte may be processed whenever the result register is empty or
	// its contents leave this cycle; otherwise the input side stalls.
	assign adv      = !out_valid_q || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			byte_s1   <= byte_value;
		end
	end

	at_rlc_parser #(
		.LINE_BUF_SIZE(LINE_BUF_SIZE)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.action     (action_s1),
		.byte_value (byte_s1),
		.res        (res)
	);

	// Result register: a taken result frees the slot, a new result fills it in
	// the same cycle, so back-to-back lines stream without a gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (res.valid) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			class_q <= res.line_class;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_class = class_q;

	// a result is only produced by a byte that advances into a free slot
	`AT_RLC_ASSERT_IMP(a_res_needs_slot, res.valid, step && adv, "result without free slot")
	// a held stage keeps its byte while stalled
	`AT_RLC_ASSERT_NXT(a_stage_holds, valid_s1 && !adv, valid_s1 && $stable(byte_s1) && $stable(action_s1), "stalled stage changed")
	// only defined class codes leave the block
	`AT_RLC_ASSERT_IMP(a_class_range, out_valid_q, class_q <= CLASS_OVERFLOW, "class code out of range")

endmodule

`default_nettype wire
